[hw/rtl/semicolon_field_message_parser_macros.svh]
// Assertion macros for the semicolon field message parser.
// Define ASSERT_OFF to compile the checks out.
`ifndef SEMICOLON_FIELD_MESSAGE_PARSER_MACROS_SVH
`define SEMICOLON_FIELD_MESSAGE_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define SFMP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sfmp assertion failed");
// cond must never be true outside reset
`define SFMP_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("sfmp forbidden condition seen");
`else
`define SFMP_ASSERT(label, clk, rstn, prop)
`define SFMP_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

[hw/rtl/sfmp_pkg.sv]
`timescale 1ns / 1ps
package sfmp_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned NAME_LEN_W = 6;
    localparam int unsigned FIELDS     = 4;
    localparam int unsigned MIN_NAME   = 3;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NAME     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NAME_OVF = 3'd7;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CS_RUN,
        CS_FETCH,
        CS_LOAD
    } sfmp_state_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } sfmp_phase_t;

    // controller -> datapath
    typedef struct packed {
        logic byte_step;    // parse one accepted non-null byte
        logic end_capture;  // message ends on this item
        logic name_rd;      // read name buffer at current index
        logic name_load;    // load name byte into output register
        logic sum_load;     // load summary, clear message state
    } sfmp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic names_left;
    } sfmp_stat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic [VALUE_W-1:0] number_value(input logic neg,
                                                       input logic [VALUE_W-1:0] mag);
        if (neg) begin
            return VALUE_W'(0) - mag;
        end
        return (mag > POS_MAX) ? POS_MAX : mag;
    endfunction

endpackage

[hw/rtl/sfmp_ram.sv]
`timescale 1ns / 1ps
module sfmp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sfmp_ctrl.sv]
`timescale 1ns / 1ps
`include "semicolon_field_message_parser_macros.svh"
module sfmp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_end_of_message,
    input  logic                s_null_message,
    output logic                m_valid,
    input  logic                m_ready,
    output sfmp_pkg::sfmp_cmd_t cmd,
    input  sfmp_pkg::sfmp_stat_t stat
);
    import sfmp_pkg::*;

    sfmp_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ready is high throughout CS_RUN, so valid alone marks an accepted item
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            CS_RUN: begin
                s_ready = 1'b1;
                cmd.byte_step   = s_valid && !s_null_message;
                cmd.end_capture = s_valid && (s_null_message || s_end_of_message);
                if (cmd.end_capture) begin
                    state_next = CS_FETCH;
                end
            end
            CS_FETCH: begin
                if (stat.names_left) begin
                    cmd.name_rd = 1'b1;
                    state_next  = CS_LOAD;
                end else if (out_free) begin
                    cmd.sum_load = 1'b1;
                    state_next   = CS_RUN;
                end
            end
            CS_LOAD: begin
                if (out_free) begin
                    cmd.name_load = 1'b1;
                    state_next    = CS_FETCH;
                end
            end
            default: begin
                state_next = CS_RUN;
            end
        endcase
    end

    always_comb begin
        if (cmd.name_load || cmd.sum_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `SFMP_ASSERT_NEVER(a_load_into_busy, aclk, aresetn, (cmd.name_load || cmd.sum_load) && !out_free)
    `SFMP_ASSERT(a_sum_returns_run, aclk, aresetn, cmd.sum_load |=> s_ready)
    `SFMP_ASSERT(a_read_then_load, aclk, aresetn, cmd.name_rd |=> (state_reg == CS_LOAD))

endmodule

[hw/rtl/sfmp_datapath.sv]
`timescale 1ns / 1ps
`include "semicolon_field_message_parser_macros.svh"
module sfmp_datapath #(
    parameter int unsigned MAX_MESSAGE = 1024,
    parameter int unsigned NAME_BYTES  = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sfmp_pkg::sfmp_cmd_t                  cmd,
    output sfmp_pkg::sfmp_stat_t                 stat,
    input  logic [7:0]                           s_byte_in,
    input  logic                                 s_null_message,
    output logic                                 m_kind,
    output logic [7:0]                           m_name_char,
    output logic [sfmp_pkg::STATUS_W-1:0]        m_status,
    output logic signed [sfmp_pkg::VALUE_W-1:0]  m_employee,
    output logic signed [sfmp_pkg::VALUE_W-1:0]  m_job,
    output logic signed [sfmp_pkg::VALUE_W-1:0]  m_company,
    output logic [sfmp_pkg::NAME_LEN_W-1:0]      m_name_length,
    output logic                                 m_run_last
);
    import sfmp_pkg::*;

    localparam int unsigned BC_W = $clog2(MAX_MESSAGE + 2);
    localparam int unsigned FL_W = $clog2(NAME_BYTES + 2);  // saturates at NAME_BYTES+1
    localparam int unsigned K_W  = $clog2(NAME_BYTES + 1);
    localparam int unsigned AW   = $clog2(NAME_BYTES);
    localparam int unsigned MW   = VALUE_W + 4;

    // message state
    logic [BC_W-1:0]     byte_count_reg, byte_count_next;
    logic [2:0]          field_index_reg, field_index_next;
    logic [FL_W-1:0]     field_length_reg, field_length_next;
    sfmp_phase_t         phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [VALUE_W-1:0]  employee_reg, employee_next;
    logic [VALUE_W-1:0]  job_reg, job_next;
    logic [VALUE_W-1:0]  company_reg, company_next;
    logic [K_W-1:0]      stored_len_reg, stored_len_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                ovf_reg, ovf_next;
    logic                null_reg, null_next;
    logic [K_W-1:0]      k_reg, k_next;

    // output register payload
    logic                kind_reg;
    logic [7:0]          char_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  emp_out_reg, job_out_reg, comp_out_reg;
    logic [NAME_LEN_W-1:0] len_out_reg;
    logic                last_reg;

    logic                ram_we;
    logic [7:0]          ram_rdata;

    logic                is_digit, is_sign, is_ws;
    logic [MW-1:0]       acc_wide, acc_prod;
    logic [VALUE_W-1:0]  acc_step;
    logic [VALUE_W-1:0]  cur_value;
    logic [STATUS_W-1:0] status_now;
    logic [K_W-1:0]      emit_len;

    assign is_digit = (s_byte_in >= CHAR_ZERO) && (s_byte_in <= CHAR_NINE);
    assign is_sign  = (s_byte_in == CHAR_PLUS) || (s_byte_in == CHAR_MINUS);
    assign is_ws    = is_space(s_byte_in);

    // acc*10 + digit, clamped to 2^31
    assign acc_wide = MW'(acc_reg);
    assign acc_prod = (acc_wide << 3) + (acc_wide << 1) + MW'(s_byte_in - CHAR_ZERO);
    assign acc_step = (acc_prod > MW'(MAG_LIMIT)) ? MAG_LIMIT : acc_prod[VALUE_W-1:0];

    assign cur_value = number_value(neg_reg, acc_reg);

    always_comb begin
        if (null_reg) begin
            status_now = STATUS_NULL;
        end else if (byte_count_reg > BC_W'(MAX_MESSAGE)) begin
            status_now = STATUS_OVERSIZE;
        end else if (err_reg != STATUS_OK) begin
            status_now = err_reg;
        end else if (field_index_reg < 3'(FIELDS)) begin
            status_now = STATUS_NAME + field_index_reg;
        end else begin
            status_now = ovf_reg ? STATUS_NAME_OVF : STATUS_OK;
        end
    end

    assign emit_len = (!null_reg && (status_now != STATUS_OVERSIZE) && (field_index_reg != 3'd0))
                      ? stored_len_reg : K_W'(0);
    assign stat.names_left = k_reg < emit_len;

    always_comb begin
        byte_count_next   = byte_count_reg;
        field_index_next  = field_index_reg;
        field_length_next = field_length_reg;
        phase_next        = phase_reg;
        neg_next          = neg_reg;
        acc_next          = acc_reg;
        employee_next     = employee_reg;
        job_next          = job_reg;
        company_next      = company_reg;
        stored_len_next   = stored_len_reg;
        err_next          = err_reg;
        ovf_next          = ovf_reg;
        null_next         = null_reg;
        k_next            = k_reg;
        ram_we            = 1'b0;
        if (cmd.sum_load) begin
            byte_count_next   = '0;
            field_index_next  = '0;
            field_length_next = '0;
            phase_next        = PH_SKIP;
            neg_next          = 1'b0;
            acc_next          = '0;
            employee_next     = '0;
            job_next          = '0;
            company_next      = '0;
            stored_len_next   = '0;
            err_next          = STATUS_OK;
            ovf_next          = 1'b0;
            null_next         = 1'b0;
            k_next            = '0;
        end else begin
            if (cmd.end_capture) begin
                null_next = s_null_message;
            end
            if (cmd.name_load) begin
                k_next = k_reg + K_W'(1);
            end
            if (cmd.byte_step) begin
                if (byte_count_reg <= BC_W'(MAX_MESSAGE)) begin
                    byte_count_next = byte_count_reg + BC_W'(1);
                end
                if ((err_reg == STATUS_OK) && (field_index_reg < 3'(FIELDS))) begin
                    if (s_byte_in == CHAR_SEMI) begin
                        if (field_index_reg == 3'd0) begin
                            if (field_length_reg < FL_W'(MIN_NAME)) begin
                                err_next = STATUS_NAME;
                            end else begin
                                stored_len_next = (field_length_reg > FL_W'(NAME_BYTES))
                                                  ? K_W'(NAME_BYTES) : K_W'(field_length_reg);
                                ovf_next = field_length_reg > FL_W'(NAME_BYTES);
                            end
                        end else if (field_length_reg == '0) begin
                            err_next = STATUS_NAME + field_index_reg;
                        end else begin
                            case (field_index_reg)
                                3'd1:    employee_next = cur_value;
                                3'd2:    job_next      = cur_value;
                                default: company_next  = cur_value;
                            endcase
                        end
                        // advance to next field unless this terminator failed
                        if (err_next == STATUS_OK) begin
                            field_index_next  = field_index_reg + 3'd1;
                            field_length_next = '0;
                            phase_next        = PH_SKIP;
                            neg_next          = 1'b0;
                            acc_next          = '0;
                        end
                    end else begin
                        if (field_index_reg == 3'd0) begin
                            ram_we = field_length_reg < FL_W'(NAME_BYTES);
                        end else begin
                            case (phase_reg)
                                PH_SKIP: begin
                                    if (is_sign) begin
                                        neg_next   = s_byte_in == CHAR_MINUS;
                                        phase_next = PH_DIGITS;
                                    end else if (!is_ws) begin
                                        if (is_digit) begin
                                            acc_next   = acc_step;
                                            phase_next = PH_DIGITS;
                                        end else begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                end
                                PH_DIGITS: begin
                                    if (is_digit) begin
                                        acc_next = acc_step;
                                    end else begin
                                        phase_next = PH_DONE;
                                    end
                                end
                                default: begin
                                    phase_next = phase_reg;
                                end
                            endcase
                        end
                        if (field_length_reg <= FL_W'(NAME_BYTES)) begin
                            field_length_next = field_length_reg + FL_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            field_index_reg  <= '0;
            field_length_reg <= '0;
            phase_reg        <= PH_SKIP;
            neg_reg          <= 1'b0;
            acc_reg          <= '0;
            employee_reg     <= '0;
            job_reg          <= '0;
            company_reg      <= '0;
            stored_len_reg   <= '0;
            err_reg          <= STATUS_OK;
            ovf_reg          <= 1'b0;
            null_reg         <= 1'b0;
            k_reg            <= '0;
        end else begin
            byte_count_reg   <= byte_count_next;
            field_index_reg  <= field_index_next;
            field_length_reg <= field_length_next;
            phase_reg        <= phase_next;
            neg_reg          <= neg_next;
            acc_reg          <= acc_next;
            employee_reg     <= employee_next;
            job_reg          <= job_next;
            company_reg      <= company_next;
            stored_len_reg   <= stored_len_next;
            err_reg          <= err_next;
            ovf_reg          <= ovf_next;
            null_reg         <= null_next;
            k_reg            <= k_next;
        end
    end

    // output register payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.name_load) begin
            kind_reg     <= 1'b0;
            char_reg     <= ram_rdata;
            status_reg   <= STATUS_OK;
            emp_out_reg  <= '0;
            job_out_reg  <= '0;
            comp_out_reg <= '0;
            len_out_reg  <= '0;
            last_reg     <= 1'b0;
        end else if (cmd.sum_load) begin
            kind_reg     <= 1'b1;
            char_reg     <= '0;
            status_reg   <= status_now;
            emp_out_reg  <= employee_reg;
            job_out_reg  <= job_reg;
            comp_out_reg <= company_reg;
            len_out_reg  <= NAME_LEN_W'(k_reg);
            last_reg     <= 1'b1;
        end
    end

    sfmp_ram #(
        .WIDTH(8),
        .DEPTH(NAME_BYTES)
    ) u_name_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(field_length_reg[AW-1:0]),
        .wdata(s_byte_in),
        .re   (cmd.name_rd),
        .raddr(k_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign m_kind        = kind_reg;
    assign m_name_char   = char_reg;
    assign m_status      = status_reg;
    assign m_employee    = $signed(emp_out_reg);
    assign m_job         = $signed(job_out_reg);
    assign m_company     = $signed(comp_out_reg);
    assign m_name_length = len_out_reg;
    assign m_run_last    = last_reg;

    `SFMP_ASSERT(a_sum_clears, aclk, aresetn, cmd.sum_load |=> ((byte_count_reg == '0) && (field_index_reg == '0)))
    `SFMP_ASSERT(a_err_sticky, aclk, aresetn, ((err_reg != STATUS_OK) && !cmd.sum_load) |=> (err_reg == $past(err_reg)))
    `SFMP_ASSERT(a_load_in_range, aclk, aresetn, cmd.name_load |-> (k_reg < emit_len))

endmodule

[hw/rtl/semicolon_field_message_parser.sv]
`timescale 1ns / 1ps
// Semicolon field message parser. A message streams in one byte per item:
// a name and three decimal integers (employee, job, company), each closed
// by ';'. Integers follow atoi rules (leading whitespace, optional sign,
// digits up to the first non-digit, clamped to 32 bits). Every non-final
// byte is accepted without stalling and yields no result. On the final byte (or a
// null-message item) the block stops taking input and emits the stored
// name bytes, then one summary item with status and values; each name byte
// is a name buffer read (registered) followed by an output load, and any
// output stall holds the burst. Input is taken again the cycle after the
// summary enters the output register, even while it waits to be taken.
module semicolon_field_message_parser #(
    parameter int unsigned MAX_MESSAGE = 1024,  // longer messages report oversize
    parameter int unsigned NAME_BYTES  = 32     // name buffer depth, 3..63
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // byte input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_byte_in,
    input  logic                                 s_end_of_message,
    input  logic                                 s_null_message,
    // results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [7:0]                           m_name_char,
    output logic [sfmp_pkg::STATUS_W-1:0]        m_status,
    output logic signed [sfmp_pkg::VALUE_W-1:0]  m_employee,
    output logic signed [sfmp_pkg::VALUE_W-1:0]  m_job,
    output logic signed [sfmp_pkg::VALUE_W-1:0]  m_company,
    output logic [sfmp_pkg::NAME_LEN_W-1:0]      m_name_length,
    output logic                                 m_run_last
);
    import sfmp_pkg::*;

    sfmp_cmd_t  cmd;
    sfmp_stat_t stat;

    // Sequencer: byte intake, then name burst, then summary.
    sfmp_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_end_of_message(s_end_of_message),
        .s_null_message  (s_null_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .stat            (stat)
    );

    // Field parsing, integer conversion, name buffer and output payload.
    sfmp_datapath #(
        .MAX_MESSAGE(MAX_MESSAGE),
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_byte_in    (s_byte_in),
        .s_null_message(s_null_message),
        .m_kind       (m_kind),
        .m_name_char  (m_name_char),
        .m_status     (m_status),
        .m_employee   (m_employee),
        .m_job        (m_job),
        .m_company    (m_company),
        .m_name_length(m_name_length),
        .m_run_last   (m_run_last)
    );

endmodule
